/* hw/rtl/rebd_pkg.sv */
package rebd_pkg;

    // Item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // Reset value of the long press threshold
    localparam logic [7:0] LONG_PRESS_RESET = 8'd10;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PROGRESS = 3'd1,
        EV_SHORT    = 3'd2,
        EV_LONG     = 3'd3,
        EV_RIGHT    = 3'd4,
        EV_LEFT     = 3'd5
    } event_t;

    // Latched turn direction
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2,
        DIR_BAD  = 2'd3
    } dir_t;

    typedef struct packed {
        dir_t       dir;
        logic [2:0] next_phase;
    } step_entry_t;

    // Full-step quadrature table: [phase][{b, a}] -> {dir, next phase}
    localparam logic [4:0] STEP_TABLE [8][4] = '{
        '{5'b00_000, 5'b00_010, 5'b00_100, 5'b00_000},
        '{5'b00_011, 5'b00_000, 5'b00_001, 5'b01_000},
        '{5'b00_011, 5'b00_010, 5'b00_000, 5'b00_000},
        '{5'b00_011, 5'b00_010, 5'b00_001, 5'b00_000},
        '{5'b00_110, 5'b00_000, 5'b00_100, 5'b00_000},
        '{5'b00_110, 5'b00_101, 5'b00_000, 5'b10_000},
        '{5'b00_110, 5'b00_101, 5'b00_100, 5'b00_000},
        '{5'b00_000, 5'b00_010, 5'b00_100, 5'b00_000}
    };

    function automatic step_entry_t step_lookup(input logic [2:0] phase,
                                                input logic [1:0] pins);
        step_entry_t e;
        e = step_entry_t'(STEP_TABLE[phase][pins]);
        return e;
    endfunction

endpackage

/* hw/rtl/rotary_encoder_and_button_decoder_core.sv */
// Rotary encoder and push-button decoder. Encoder samples (op = 0) step a
// seven-state full-step quadrature table and latch a completed clockwise or
// counter-clockwise detent; they produce no result. Poll ticks (op = 1)
// classify the active-low button level and produce exactly one event code:
// press in progress, short press, long press, or, when the button has nothing
// to report, the latched turn (right / left, which clears the latch) or none.
// Throughput is one transaction per clock unless the input is stalled; a poll
// result passes through the input register, then the result register. The
// only stall source is a held result register backing up into the input
// register.
// long_press_ticks may only be written while no transaction is in flight.
module rotary_encoder_and_button_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic       pin_a,
    input  logic       pin_b,
    input  logic       button_level,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_code
);

    // Configuration and decoder state
    logic [7:0]          long_press_ticks_reg;
    logic [2:0]          phase_reg, phase_next;
    rebd_pkg::dir_t      latch_reg, latch_next;
    logic                prev_reg, prev_next;
    logic [7:0]          count_reg, count_next;
    logic                await_reg, await_next;

    // Input stage
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_op_reg;
    logic                s1_a_reg;
    logic                s1_b_reg;
    logic                s1_level_reg;

    // Result stage
    logic                out_valid_reg, out_valid_next;
    rebd_pkg::event_t    event_reg, event_next;

    logic                in_accept;
    logic                out_free;
    logic                s1_advance;
    logic                s1_poll;
    logic [7:0]          count_inc;
    rebd_pkg::step_entry_t step;

    // Handshake
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_poll    = (s1_op_reg == rebd_pkg::OP_POLL);
    assign s1_advance = s1_valid_reg && (!s1_poll || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

    assign count_inc  = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
    assign step       = rebd_pkg::step_lookup(phase_reg, {s1_b_reg, s1_a_reg});

    // Decode of the staged transaction
    always_comb
    begin
        phase_next = phase_reg;
        latch_next = latch_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        await_next = await_reg;
        event_next = rebd_pkg::EV_NONE;

        if (!s1_poll)
        begin
            phase_next = step.next_phase;
            if (step.dir != rebd_pkg::DIR_IDLE)
                latch_next = step.dir;
        end
        else
        begin
            if (await_reg)
            begin
                // long press already reported: wait for release
                if (s1_level_reg)
                    await_next = 1'b0;
                prev_next  = 1'b1;
                count_next = 8'd0;
            end
            else
            begin
                case ({prev_reg, s1_level_reg})
                    2'b00:
                    begin
                        count_next = count_inc;
                        if (count_inc > long_press_ticks_reg)
                        begin
                            event_next = rebd_pkg::EV_LONG;
                            await_next = 1'b1;
                        end
                        else
                            event_next = rebd_pkg::EV_PROGRESS;
                    end
                    2'b01:
                    begin
                        event_next = (count_reg < long_press_ticks_reg) ?
                                     rebd_pkg::EV_SHORT : rebd_pkg::EV_LONG;
                        count_next = 8'd0;
                    end
                    2'b10:
                    begin
                        count_next = count_inc;
                        event_next = rebd_pkg::EV_PROGRESS;
                    end
                    default:
                    begin
                        count_next = 8'd0;
                    end
                endcase
                prev_next = s1_level_reg;
            end

            // button quiet: report and clear the latched turn
            if (event_next == rebd_pkg::EV_NONE)
            begin
                if (latch_reg == rebd_pkg::DIR_CW)
                    event_next = rebd_pkg::EV_RIGHT;
                else if (latch_reg == rebd_pkg::DIR_CCW)
                    event_next = rebd_pkg::EV_LEFT;
                latch_next = rebd_pkg::DIR_IDLE;
            end
        end
    end

    // Stage valid bits
    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_advance && s1_poll)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= rebd_pkg::LONG_PRESS_RESET;
            phase_reg            <= 3'd0;
            latch_reg            <= rebd_pkg::DIR_IDLE;
            prev_reg             <= 1'b1;
            count_reg            <= 8'd0;
            await_reg            <= 1'b0;
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                long_press_ticks_reg <= cfg_write_data;
            if (s1_advance)
            begin
                phase_reg <= phase_next;
                latch_reg <= latch_next;
                prev_reg  <= prev_next;
                count_reg <= count_next;
                await_reg <= await_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= op;
            s1_a_reg     <= pin_a;
            s1_b_reg     <= pin_b;
            s1_level_reg <= button_level;
        end
        if (s1_advance && s1_poll)
            event_reg <= event_next;
    end

`ifndef SYNTHESIS
    a_phase_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 3'd7)
        else $error("encoder phase reached unused code");

    a_latch_code: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg != rebd_pkg::DIR_BAD)
        else $error("direction latch holds unused code");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_poll && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !s1_poll && out_free) |=> !out_valid)
        else $error("encoder sample produced a result");

    a_await_after_long: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(await_reg) |-> (out_valid && event_code == rebd_pkg::EV_LONG))
        else $error("release wait entered without a long press");
`endif

endmodule

/* verif/rebd_event_checker.sv */
// Watches both channels of the encoder/button decoder, predicts the event
// code of every poll tick and compares it with what comes out.
module rebd_event_checker
    import rebd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       op,
    input  logic       pin_a,
    input  logic       pin_b,
    input  logic       button_level,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] event_code,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        dir_t       turn;
        logic [2:0] phase;
    } quad_move_t;

    // Predicted block state
    logic [7:0] threshold;
    logic [2:0] enc_phase;
    dir_t       latched_turn;
    logic       btn_prev;
    logic [7:0] press_cnt;
    logic       awaiting_release;

    event_t expected_events[$];

    // One step of the full-step quadrature table; ba = {pin_b, pin_a}
    function automatic quad_move_t quad_step(input logic [2:0] ph, input logic [1:0] ba);
        quad_move_t m;
        logic [11:0] nexts;  // {next for ba=3, 2, 1, 0}
        case (ph)
            3'd1:    nexts = {3'd0, 3'd1, 3'd0, 3'd3};
            3'd2:    nexts = {3'd0, 3'd0, 3'd2, 3'd3};
            3'd3:    nexts = {3'd0, 3'd1, 3'd2, 3'd3};
            3'd4:    nexts = {3'd0, 3'd4, 3'd0, 3'd6};
            3'd5:    nexts = {3'd0, 3'd0, 3'd5, 3'd6};
            3'd6:    nexts = {3'd0, 3'd4, 3'd5, 3'd6};
            default: nexts = {3'd0, 3'd4, 3'd2, 3'd0};  // start state, and phase 7
        endcase
        m.phase = nexts[ba*3 +: 3];
        m.turn  = DIR_IDLE;
        if (ba == 2'b11 && ph == 3'd1)
            m.turn = DIR_CW;
        else if (ba == 2'b11 && ph == 3'd5)
            m.turn = DIR_CCW;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        quad_move_t mv;
        event_t     ev;
        event_t     want;
        if (!rst_n)
        begin
            threshold        = LONG_PRESS_RESET;
            enc_phase        = 3'd0;
            latched_turn     = DIR_IDLE;
            btn_prev         = 1'b1;
            press_cnt        = 8'd0;
            awaiting_release = 1'b0;
            expected_events.delete();
            fail_count       = 0;
            outstanding      = 0;
        end
        else
        begin
            // Result side
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: event_code with nothing pending, expected none, got %0d",
                             $time, event_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_code !== want)
                    begin
                        $display("%0t: event_code mismatch, expected %0d (%s), got %0d",
                                 $time, want, want.name(), event_code);
                        fail_count++;
                    end
                end
            end

            // Threshold register
            if (cfg_write_en)
                threshold = cfg_write_data;

            // Input side
            if (in_valid && !in_stall)
            begin
                if (op == OP_SAMPLE)
                begin
                    mv = quad_step(enc_phase, {pin_b, pin_a});
                    enc_phase = mv.phase;
                    if (mv.turn != DIR_IDLE)
                        latched_turn = mv.turn;
                end
                else
                begin
                    // Press classifier
                    if (awaiting_release)
                    begin
                        if (button_level)
                            awaiting_release = 1'b0;
                        btn_prev  = 1'b1;
                        press_cnt = 8'd0;
                        ev        = EV_NONE;
                    end
                    else
                    begin
                        case ({btn_prev, button_level})
                            2'b00:
                            begin
                                if (press_cnt != 8'hFF)
                                    press_cnt = press_cnt + 8'd1;
                                if (press_cnt > threshold)
                                begin
                                    awaiting_release = 1'b1;
                                    ev = EV_LONG;
                                end
                                else
                                    ev = EV_PROGRESS;
                            end
                            2'b01:
                            begin
                                ev = (press_cnt < threshold) ? EV_SHORT : EV_LONG;
                                press_cnt = 8'd0;
                            end
                            2'b10:
                            begin
                                if (press_cnt != 8'hFF)
                                    press_cnt = press_cnt + 8'd1;
                                ev = EV_PROGRESS;
                            end
                            default:
                            begin
                                press_cnt = 8'd0;
                                ev = EV_NONE;
                            end
                        endcase
                        btn_prev = button_level;
                    end

                    // Turn is reported only when the button is quiet
                    if (ev == EV_NONE)
                    begin
                        if (latched_turn == DIR_CW)
                            ev = EV_RIGHT;
                        else if (latched_turn == DIR_CCW)
                            ev = EV_LEFT;
                        latched_turn = DIR_IDLE;
                    end
                    expected_events.push_back(ev);
                end
            end
            outstanding = expected_events.size();
        end
    end

endmodule

/* verif/rotary_encoder_and_button_decoder_core_tb.sv */
module rotary_encoder_and_button_decoder_core_tb;
    import rebd_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write_en;
    logic [7:0] cfg_write_data;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic       pin_a;
    logic       pin_b;
    logic       button_level;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] event_code;

    int fail_count;
    int outstanding;
    int sent_items;
    int burst_left;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rotary_encoder_and_button_decoder_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .pin_a          (pin_a),
        .pin_b          (pin_b),
        .button_level   (button_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_code     (event_code)
    );

    rebd_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .pin_a          (pin_a),
        .pin_b          (pin_b),
        .button_level   (button_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_code     (event_code),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // One transaction; the sender idles between bursts of random length
    task automatic push_item(input logic kind, input logic a, input logic b, input logic lvl);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(8, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        in_valid     <= 1'b1;
        op           <= kind;
        pin_a        <= a;
        pin_b        <= b;
        button_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent_items++;
    endtask

    // ba = {pin_b, pin_a}
    task automatic sample(input logic [1:0] ba);
        push_item(OP_SAMPLE, ba[0], ba[1], 1'($urandom_range(0, 1)));
    endtask

    task automatic poll(input logic lvl);
        push_item(OP_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), lvl);
    endtask

    // Full detent from rest, optionally with contact bounce
    task automatic turn(input logic ccw, input logic bouncy);
        logic [1:0] seq [4];
        if (ccw)
            seq = '{2'b10, 2'b00, 2'b01, 2'b11};
        else
            seq = '{2'b01, 2'b00, 2'b10, 2'b11};
        for (int i = 0; i < 4; i++)
        begin
            if (bouncy && i > 0 && $urandom_range(0, 3) == 0)
            begin
                sample(seq[i]);
                sample(seq[i-1]);
            end
            sample(seq[i]);
        end
    endtask

    // Button held for a number of poll ticks, then released; turns may interleave
    task automatic press(input int hold);
        for (int k = 0; k < hold; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                turn(1'($urandom_range(0, 1)), 1'b0);
            poll(1'b0);
        end
        poll(1'b1);
    endtask

    // Drain all results, then let any sample still in the pipe finish
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [7:0] value);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Mostly well-formed turns and presses, some idle polls and noise
    task automatic random_phase(input int budget, input int thr);
        int start_count;
        int pick;
        int hold;
        start_count = sent_items;
        while (sent_items - start_count < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                turn(1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
            else if (pick < 7)
            begin
                hold = $urandom_range(1, 6);
                pick = $urandom_range(0, (thr > 40) ? 19 : 5);
                if (pick == 0)
                    hold = thr + $urandom_range(1, 8);  // held past the threshold
                else if (pick == 1)
                    hold = (thr > 1) ? thr - 1 + $urandom_range(0, 2) : $urandom_range(1, 2);
                press(hold);
            end
            else if (pick < 9)
                repeat ($urandom_range(1, 4)) poll(1'b1);
            else
                repeat ($urandom_range(1, 6))
                    push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver stall pattern: changes character every so often
    initial
    begin : receiver
        int         mode;
        int         span;
        logic [7:0] pattern;
        wait (rst_n === 1'b1);
        forever
        begin
            mode    = $urandom_range(0, 3);
            span    = $urandom_range(20, 150);
            pattern = 8'($urandom);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2:
                    begin
                        out_stall <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] thr_list [8];
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 8'd0;
        in_valid       = 1'b0;
        op             = OP_SAMPLE;
        pin_a          = 1'b1;
        pin_b          = 1'b1;
        button_level   = 1'b1;
        out_stall      = 1'b0;
        sent_items     = 0;
        burst_left     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle, right turn, left turn, button over a pending turn
        poll(1'b1);
        turn(1'b0, 1'b0);
        poll(1'b1);
        turn(1'b1, 1'b0);
        poll(1'b0);
        poll(1'b1);
        poll(1'b1);

        // Threshold sweeps, extremes included, then random settings
        thr_list = '{8'd1, 8'd254, 8'd0, 8'd255, LONG_PRESS_RESET, 8'd0, 8'd0, 8'd0};
        thr_list[5] = 8'($urandom_range(2, 30));
        thr_list[6] = 8'($urandom_range(1, 254));
        thr_list[7] = 8'($urandom_range(2, 8));
        random_phase(60, LONG_PRESS_RESET);
        foreach (thr_list[p])
        begin
            set_threshold(thr_list[p]);
            random_phase(70, thr_list[p]);
        end

        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rebd_pkg.sv
hw/rtl/rotary_encoder_and_button_decoder_core.sv
verif/rebd_event_checker.sv
verif/rotary_encoder_and_button_decoder_core_tb.sv
